// ===== src/pnorm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnorm_pkg
// Shared widths, payload types, state and command types of the point set
// normalizer.
// ----------------------------------------------------------------------------
package pnorm_pkg;

   localparam int MAX_POINTS = 64;

   localparam int COORD_W    = 16;
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int SUM_W      = COORD_W + $clog2(MAX_POINTS);
   localparam int DIFF_W     = SUM_W + 1;
   localparam int DEV_W      = SUM_W + IDX_W;
   localparam int SCALE_W    = 24;
   localparam int NORM_W     = 16;
   localparam int OFF_W      = 32;
   localparam int PROD_W     = SUM_W + SCALE_W;
   localparam int DIVIDEND_W = PROD_W + 1;
   localparam int NN_W       = 2 * CNT_W;
   localparam int ENTRY_W    = 2 * COORD_W;

   localparam logic [SCALE_W-1:0] SCALE_MAX = {SCALE_W{1'b1}};

   typedef struct packed {
      logic [COORD_W-1:0] point_x;
      logic [COORD_W-1:0] point_y;
      logic               set_end;
   } req_type;

   typedef struct packed {
      logic signed [NORM_W-1:0] norm_x;
      logic signed [NORM_W-1:0] norm_y;
      logic [SCALE_W-1:0]       scale_x;
      logic [SCALE_W-1:0]       scale_y;
      logic signed [OFF_W-1:0]  offset_x;
      logic signed [OFF_W-1:0]  offset_y;
      logic                     run_end;
      logic                     degenerate;
      logic                     overflowed;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_LOAD, ST_DEV_RD, ST_DEV_SUB, ST_DEV_ACC,
      ST_SCX_GO, ST_SCX_WAIT, ST_SCY_GO, ST_SCY_WAIT,
      ST_OFF_MUL, ST_OFX_GO, ST_OFX_WAIT, ST_OFY_GO, ST_OFY_WAIT,
      ST_EM_RD, ST_EM_SUB, ST_EM_MUL, ST_NX_GO, ST_NX_WAIT,
      ST_NY_GO, ST_NY_WAIT, ST_EM_OUT
   } state_type;

   typedef enum logic [2:0] {
      DIV_SCX, DIV_SCY, DIV_OFX, DIV_OFY, DIV_NX, DIV_NY
   } div_op_type;

   typedef struct packed {
      logic       load;
      logic       pass_init;
      logic       sub;
      logic       dev_acc;
      logic       off_mul;
      logic       em_mul;
      logic       div_start;
      logic       div_capture;
      div_op_type div_op;
      logic       idx_inc;
      logic       set_clear;
   } cmd_type;

   typedef struct packed {
      logic idx_last;
      logic div_done;
   } status_type;

endpackage

// ===== src/pnorm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnorm_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module pnorm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== src/pnorm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnorm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pnorm_div
   import pnorm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DEV_W-1:0]      divisor,
   output logic                  busy,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DEV_W-1:0]      rem_ff, rem_in;
   logic [DEV_W-1:0]      den_ff, den_in;
   logic [STEP_W-1:0]     cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DEV_W:0]        shifted;

   // one compare and subtract per cycle
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = STEP_W'(DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = DEV_W'(shifted - {1'b0, den_ff});
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DEV_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== src/pnorm_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnorm_datapath
// Point store, sums, deviation accumulators, divider and result registers.
// ----------------------------------------------------------------------------
module pnorm_datapath
   import pnorm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_item,
   input  cmd_type    cmd,
   output status_type status,
   output rsp_type    rsp_item
);

   logic [CNT_W-1:0]    count_ff, count_in;
   logic [SUM_W-1:0]    sumx_ff, sumx_in, sumy_ff, sumy_in;
   logic                dropped_ff, dropped_in;
   logic                deg_ff, deg_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [DEV_W-1:0]    ax_ff, ax_in, ay_ff, ay_in;
   logic [DIFF_W-1:0]   dx_ff, dx_in, dy_ff, dy_in;
   logic                negx_ff, negx_in, negy_ff, negy_in;
   logic [PROD_W-1:0]   prodx_ff, prodx_in, prody_ff, prody_in;
   logic [SCALE_W-1:0]  scx_ff, scx_in, scy_ff, scy_in;
   logic [OFF_W-1:0]    offx_ff, offx_in, offy_ff, offy_in;
   logic [NORM_W-1:0]   nx_ff, nx_in, ny_ff, ny_in;

   logic                   ram_we;
   logic [ENTRY_W-1:0]     ram_rdata;
   logic [SUM_W-1:0]       ncx, ncy, magx, magy;
   logic [NN_W-1:0]        nn;
   logic [DIVIDEND_W-1:0]  div_dividend, div_quo;
   logic [DEV_W-1:0]       div_divisor;
   logic                   div_busy, div_done;
   logic [SCALE_W-1:0]     q_scale;
   logic [OFF_W-1:0]       q_off;
   logic [NORM_W-1:0]      q_norm_pos, q_norm_neg;

   assign ram_we = cmd.load && (count_ff < CNT_W'(MAX_POINTS));

   pnorm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_POINTS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (count_ff[IDX_W-1:0]),
      .wdata ({req_item.point_x, req_item.point_y}),
      .raddr (idx_ff),
      .rdata (ram_rdata)
   );

   // operand select for the shared divider
   always_comb begin
      nn = count_ff * count_ff;
      unique case (cmd.div_op)
         DIV_SCX: begin
            div_dividend = DIVIDEND_W'({nn, 20'b0}) + DIVIDEND_W'(ax_ff >> 1);
            div_divisor  = ax_ff;
         end
         DIV_SCY: begin
            div_dividend = DIVIDEND_W'({nn, 20'b0}) + DIVIDEND_W'(ay_ff >> 1);
            div_divisor  = ay_ff;
         end
         DIV_OFX: begin
            div_dividend = DIVIDEND_W'(prodx_ff) + DIVIDEND_W'({count_ff, 3'b0});
            div_divisor  = DEV_W'({count_ff, 4'b0});
         end
         DIV_OFY: begin
            div_dividend = DIVIDEND_W'(prody_ff) + DIVIDEND_W'({count_ff, 3'b0});
            div_divisor  = DEV_W'({count_ff, 4'b0});
         end
         DIV_NX: begin
            div_dividend = DIVIDEND_W'(prodx_ff) + DIVIDEND_W'({count_ff, 7'b0});
            div_divisor  = DEV_W'({count_ff, 8'b0});
         end
         DIV_NY: begin
            div_dividend = DIVIDEND_W'(prody_ff) + DIVIDEND_W'({count_ff, 7'b0});
            div_divisor  = DEV_W'({count_ff, 8'b0});
         end
         default: begin
            div_dividend = '0;
            div_divisor  = '0;
         end
      endcase
   end

   pnorm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   // saturate the quotient for each kind of result
   always_comb begin
      q_scale = (div_quo > DIVIDEND_W'(SCALE_MAX)) ? SCALE_MAX : div_quo[SCALE_W-1:0];
      q_off   = (div_quo > (DIVIDEND_W'(1) << (OFF_W - 1))) ?
                {1'b1, {(OFF_W-1){1'b0}}} : OFF_W'(-div_quo[OFF_W-1:0]);
      q_norm_pos = (div_quo > DIVIDEND_W'({1'b0, {(NORM_W-1){1'b1}}})) ?
                   {1'b0, {(NORM_W-1){1'b1}}} : div_quo[NORM_W-1:0];
      q_norm_neg = (div_quo > (DIVIDEND_W'(1) << (NORM_W - 1))) ?
                   {1'b1, {(NORM_W-1){1'b0}}} : NORM_W'(-div_quo[NORM_W-1:0]);
   end

   // centered coordinates and their magnitudes
   always_comb begin
      ncx  = SUM_W'(count_ff) * SUM_W'(ram_rdata[ENTRY_W-1:COORD_W]);
      ncy  = SUM_W'(count_ff) * SUM_W'(ram_rdata[COORD_W-1:0]);
      magx = dx_ff[DIFF_W-1] ? SUM_W'(-dx_ff) : dx_ff[SUM_W-1:0];
      magy = dy_ff[DIFF_W-1] ? SUM_W'(-dy_ff) : dy_ff[SUM_W-1:0];
   end

   // next state of the set registers
   always_comb begin
      count_in   = count_ff;
      sumx_in    = sumx_ff;
      sumy_in    = sumy_ff;
      dropped_in = dropped_ff;
      deg_in     = deg_ff;
      idx_in     = idx_ff;
      ax_in      = ax_ff;
      ay_in      = ay_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      negx_in    = negx_ff;
      negy_in    = negy_ff;
      prodx_in   = prodx_ff;
      prody_in   = prody_ff;
      scx_in     = scx_ff;
      scy_in     = scy_ff;
      offx_in    = offx_ff;
      offy_in    = offy_ff;
      nx_in      = nx_ff;
      ny_in      = ny_ff;

      if (cmd.load) begin
         if (ram_we) begin
            count_in = count_ff + 1'b1;
            sumx_in  = sumx_ff + SUM_W'(req_item.point_x);
            sumy_in  = sumy_ff + SUM_W'(req_item.point_y);
         end else begin
            dropped_in = 1'b1;
         end
      end
      if (cmd.pass_init) begin
         idx_in = '0;
         ax_in  = '0;
         ay_in  = '0;
      end
      if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.sub) begin
         dx_in = {1'b0, ncx} - {1'b0, sumx_ff};
         dy_in = {1'b0, ncy} - {1'b0, sumy_ff};
      end
      if (cmd.dev_acc) begin
         ax_in = ax_ff + DEV_W'(magx);
         ay_in = ay_ff + DEV_W'(magy);
      end
      if (cmd.off_mul) begin
         prodx_in = sumx_ff * scx_ff;
         prody_in = sumy_ff * scy_ff;
      end
      if (cmd.em_mul) begin
         prodx_in = magx * scx_ff;
         prody_in = magy * scy_ff;
         negx_in  = dx_ff[DIFF_W-1];
         negy_in  = dy_ff[DIFF_W-1];
      end
      if (cmd.div_capture) begin
         unique case (cmd.div_op)
            DIV_SCX: begin
               scx_in = q_scale;
               if (ax_ff == '0) deg_in = 1'b1;
            end
            DIV_SCY: begin
               scy_in = q_scale;
               if (ay_ff == '0) deg_in = 1'b1;
            end
            DIV_OFX: offx_in = q_off;
            DIV_OFY: offy_in = q_off;
            DIV_NX:  nx_in = negx_ff ? q_norm_neg : q_norm_pos;
            DIV_NY:  ny_in = negy_ff ? q_norm_neg : q_norm_pos;
            default: ;
         endcase
      end
      if (cmd.set_clear) begin
         count_in   = '0;
         sumx_in    = '0;
         sumy_in    = '0;
         dropped_in = 1'b0;
         deg_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         sumx_ff    <= '0;
         sumy_ff    <= '0;
         dropped_ff <= 1'b0;
         deg_ff     <= 1'b0;
         idx_ff     <= '0;
      end else begin
         count_ff   <= count_in;
         sumx_ff    <= sumx_in;
         sumy_ff    <= sumy_in;
         dropped_ff <= dropped_in;
         deg_ff     <= deg_in;
         idx_ff     <= idx_in;
      end
      ax_ff    <= ax_in;
      ay_ff    <= ay_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      negx_ff  <= negx_in;
      negy_ff  <= negy_in;
      prodx_ff <= prodx_in;
      prody_ff <= prody_in;
      scx_ff   <= scx_in;
      scy_ff   <= scy_in;
      offx_ff  <= offx_in;
      offy_ff  <= offy_in;
      nx_ff    <= nx_in;
      ny_ff    <= ny_in;
   end

   // status and result
   always_comb begin
      status.idx_last = (CNT_W'(idx_ff) + 1'b1) == count_ff;
      status.div_done = div_done;

      rsp_item.norm_x     = nx_ff;
      rsp_item.norm_y     = ny_ff;
      rsp_item.scale_x    = scx_ff;
      rsp_item.scale_y    = scy_ff;
      rsp_item.offset_x   = offx_ff;
      rsp_item.offset_y   = offy_ff;
      rsp_item.run_end    = status.idx_last;
      rsp_item.degenerate = deg_ff;
      rsp_item.overflowed = dropped_ff;
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count exceeds capacity");

   a_clear_set : assert property (@(posedge clock) disable iff (reset)
      cmd.set_clear |=> (count_ff == '0) && !dropped_ff && !deg_ff)
      else $error("set state not cleared after last result");

   a_div_idle : assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !div_busy)
      else $error("divider started while busy");

endmodule

// ===== src/pnorm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnorm_ctrl
// Sequencer: load, deviation pass, scale and offset divisions, emit pass.
// ----------------------------------------------------------------------------
module pnorm_ctrl
   import pnorm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       set_end,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy,
   output logic       rsp_strobe
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.div_op = DIV_SCX;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               if (set_end) begin
                  cmd.pass_init = 1'b1;
                  state_in      = ST_DEV_RD;
               end
            end
         end
         ST_DEV_RD:  state_in = ST_DEV_SUB;
         ST_DEV_SUB: begin
            cmd.sub  = 1'b1;
            state_in = ST_DEV_ACC;
         end
         ST_DEV_ACC: begin
            cmd.dev_acc = 1'b1;
            if (status.idx_last) begin
               state_in = ST_SCX_GO;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_DEV_RD;
            end
         end
         ST_SCX_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_SCX_WAIT;
         end
         ST_SCX_WAIT: begin
            if (status.div_done) begin
               cmd.div_capture = 1'b1;
               state_in        = ST_SCY_GO;
            end
         end
         ST_SCY_GO: begin
            cmd.div_op    = DIV_SCY;
            cmd.div_start = 1'b1;
            state_in      = ST_SCY_WAIT;
         end
         ST_SCY_WAIT: begin
            cmd.div_op = DIV_SCY;
            if (status.div_done) begin
               cmd.div_capture = 1'b1;
               state_in        = ST_OFF_MUL;
            end
         end
         ST_OFF_MUL: begin
            cmd.off_mul = 1'b1;
            state_in    = ST_OFX_GO;
         end
         ST_OFX_GO: begin
            cmd.div_op    = DIV_OFX;
            cmd.div_start = 1'b1;
            state_in      = ST_OFX_WAIT;
         end
         ST_OFX_WAIT: begin
            cmd.div_op = DIV_OFX;
            if (status.div_done) begin
               cmd.div_capture = 1'b1;
               state_in        = ST_OFY_GO;
            end
         end
         ST_OFY_GO: begin
            cmd.div_op    = DIV_OFY;
            cmd.div_start = 1'b1;
            state_in      = ST_OFY_WAIT;
         end
         ST_OFY_WAIT: begin
            cmd.div_op = DIV_OFY;
            if (status.div_done) begin
               cmd.div_capture = 1'b1;
               cmd.pass_init   = 1'b1;
               state_in        = ST_EM_RD;
            end
         end
         ST_EM_RD:  state_in = ST_EM_SUB;
         ST_EM_SUB: begin
            cmd.sub  = 1'b1;
            state_in = ST_EM_MUL;
         end
         ST_EM_MUL: begin
            cmd.em_mul = 1'b1;
            state_in   = ST_NX_GO;
         end
         ST_NX_GO: begin
            cmd.div_op    = DIV_NX;
            cmd.div_start = 1'b1;
            state_in      = ST_NX_WAIT;
         end
         ST_NX_WAIT: begin
            cmd.div_op = DIV_NX;
            if (status.div_done) begin
               cmd.div_capture = 1'b1;
               state_in        = ST_NY_GO;
            end
         end
         ST_NY_GO: begin
            cmd.div_op    = DIV_NY;
            cmd.div_start = 1'b1;
            state_in      = ST_NY_WAIT;
         end
         ST_NY_WAIT: begin
            cmd.div_op = DIV_NY;
            if (status.div_done) begin
               cmd.div_capture = 1'b1;
               state_in        = ST_EM_OUT;
            end
         end
         ST_EM_OUT: begin
            rsp_strobe = 1'b1;
            if (status.idx_last) begin
               cmd.set_clear = 1'b1;
               state_in      = ST_LOAD;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_EM_RD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   a_last_returns : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EM_OUT && status.idx_last) |=> state_ff == ST_LOAD)
      else $error("sequencer did not return to load after last result");

   a_close_starts_pass : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && set_end) |=> state_ff == ST_DEV_RD)
      else $error("closing point did not start deviation pass");

   a_strobe_after_div : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff) == ST_NY_WAIT)
      else $error("result strobe without finished normalization");

endmodule

// ===== src/point_set_normalizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_set_normalizer
// Per-axis mean and mean absolute deviation normalization of a 2D point set.
// ----------------------------------------------------------------------------
// A point is taken whenever start is high while busy is low; up to MAX_POINTS
// points per set are stored, later ones are dropped and reported through
// overflowed. The point with set_end closes the set and raises busy until
// every result has been sent. After the closing point the set runs a
// deviation pass over the stored points, then four divisions for scales and
// offsets, then two divisions per point while emitting. All divisions use the
// single shared divider, which yields one quotient bit per cycle.
// Each result is shown for exactly one cycle with rsp_strobe high; the
// receiver has no way to stall, so it must take every strobed transaction.
// ----------------------------------------------------------------------------
module point_set_normalizer
   import pnorm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   cmd_type    cmd;
   status_type status;

   pnorm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .set_end    (req_item.set_end),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   pnorm_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .status   (status),
      .rsp_item (rsp_item)
   );

endmodule

// ===== verif/point_set_normalizer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_set_normalizer_test
// Sends point sets to the normalizer and checks every normalized transaction
// against a behavioral prediction of means, deviations, scales and offsets.
// ----------------------------------------------------------------------------
module point_set_normalizer_test;
   import pnorm_pkg::*;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;

   // Collected set state of the prediction
   logic [31:0] set_points [0:MAX_POINTS-1];
   int          set_count;
   longint      set_sum_x;
   longint      set_sum_y;
   bit          set_dropped;

   rsp_type     pending_rsp[$];
   int          error_count;

   point_set_normalizer u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item  (rsp_item)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Round num/den to nearest, ties away from zero
   function automatic longint round_div(longint num, longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic longint axis_coord(int i, bit on_x);
      return on_x ? longint'(set_points[i][31:16]) : longint'(set_points[i][15:0]);
   endfunction

   // Reciprocal mean absolute deviation in Q4.20
   function automatic longint reciprocal_deviation(bit on_x, longint s, output bit flat);
      longint dev_sum;
      longint d;
      longint q;
      dev_sum = 0;
      flat = 1'b0;
      for (int i = 0; i < set_count; i++) begin
         d = set_count * axis_coord(i, on_x) - s;
         dev_sum += (d < 0) ? -d : d;
      end
      if (dev_sum == 0) begin
         flat = 1'b1;
         return longint'(SCALE_MAX);
      end
      q = ((longint'(set_count) * set_count <<< 20) + dev_sum / 2) / dev_sum;
      return (q > longint'(SCALE_MAX)) ? longint'(SCALE_MAX) : q;
   endfunction

   // Take one point; on the closing point queue the normalized set
   task automatic predict_point(req_type pt);
      longint  scx, scy, offx, offy, dx, dy;
      bit      flat_x, flat_y;
      rsp_type r;
      if (set_count < MAX_POINTS) begin
         set_points[set_count] = {pt.point_x, pt.point_y};
         set_count++;
         set_sum_x += pt.point_x;
         set_sum_y += pt.point_y;
      end else begin
         set_dropped = 1'b1;
      end
      if (pt.set_end) begin
         scx = reciprocal_deviation(1'b1, set_sum_x, flat_x);
         scy = reciprocal_deviation(1'b0, set_sum_y, flat_y);
         offx = clamp(-round_div(set_sum_x * scx, 16 * set_count),
                      -64'sd2147483648, 64'sd2147483647);
         offy = clamp(-round_div(set_sum_y * scy, 16 * set_count),
                      -64'sd2147483648, 64'sd2147483647);
         for (int i = 0; i < set_count; i++) begin
            dx = set_count * axis_coord(i, 1'b1) - set_sum_x;
            dy = set_count * axis_coord(i, 1'b0) - set_sum_y;
            r.norm_x     = NORM_W'(clamp(round_div(dx * scx, 256 * set_count),
                                         -32768, 32767));
            r.norm_y     = NORM_W'(clamp(round_div(dy * scy, 256 * set_count),
                                         -32768, 32767));
            r.scale_x    = SCALE_W'(scx);
            r.scale_y    = SCALE_W'(scy);
            r.offset_x   = OFF_W'(offx);
            r.offset_y   = OFF_W'(offy);
            r.run_end    = (i == set_count - 1);
            r.degenerate = flat_x | flat_y;
            r.overflowed = set_dropped;
            pending_rsp = {pending_rsp, r};
         end
         set_count = 0;
         set_sum_x = 0;
         set_sum_y = 0;
         set_dropped = 1'b0;
      end
   endtask

   // Compare each strobed transaction with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected transaction %p", $time, rsp_item);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_item !== want) begin
               $display("%0t: mismatch expected %p actual %p", $time, want, rsp_item);
               error_count++;
            end
         end
      end
   end

   // Send one point after a random gap; hold start until accepted
   task automatic send_point(logic [15:0] px, logic [15:0] py, logic last);
      req_type pt;
      int      gap;
      gap = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      pt.point_x = px;
      pt.point_y = py;
      pt.set_end = last;
      start    <= 1'b1;
      req_item <= pt;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_point(pt);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic test_extremes();
      send_point(16'h0000, 16'h0000, 1'b0);
      send_point(16'hFFFF, 16'hFFFF, 1'b1);
      send_point(16'h1234, 16'hABCD, 1'b1);
      send_point(16'h0000, 16'hFFFF, 1'b0);
      send_point(16'hFFFF, 16'h0000, 1'b0);
      send_point(16'h0000, 16'hFFFF, 1'b1);
      send_point(16'h0001, 16'h8000, 1'b0);
      send_point(16'h0000, 16'h8000, 1'b0);
      send_point(16'h0000, 16'h8000, 1'b1);
      send_point(16'h7FFF, 16'h5555, 1'b0);
      send_point(16'h8000, 16'hAAAA, 1'b1);
   endtask

   // Fill beyond capacity, closing point dropped too
   task automatic test_capacity();
      for (int i = 0; i < MAX_POINTS + 3; i++)
         send_point(16'($urandom), 16'($urandom), i == MAX_POINTS + 2);
      wait_drained();
   endtask

   task automatic test_random_sets();
      int    len;
      int    sent;
      int    mode;
      logic [15:0] bx, by;
      sent = 0;
      while (sent < 400) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 70) : $urandom_range(1, 8);
         mode = $urandom_range(0, 3);
         bx = 16'($urandom);
         by = 16'($urandom);
         for (int i = 0; i < len; i++) begin
            unique case (mode)
               0: send_point(16'($urandom), 16'($urandom), i == len - 1);
               1: send_point(16'(bx + $urandom_range(0, 3)),
                             16'(by + $urandom_range(0, 3)), i == len - 1);
               2: send_point(bx, 16'($urandom), i == len - 1);
               default: send_point($urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
                                   16'($urandom), i == len - 1);
            endcase
            sent++;
         end
         if ($urandom_range(0, 15) == 0) wait_drained();
      end
   endtask

   initial begin
      start       = 1'b0;
      req_item    = '0;
      reset       = 1'b1;
      error_count = 0;
      set_count   = 0;
      set_sum_x   = 0;
      set_sum_y   = 0;
      set_dropped = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      wait_drained();
      test_capacity();
      test_random_sets();
      wait_drained();
      repeat (50) @(posedge clock);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
